FILE: src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and constants shared by the countdown shutdown timer.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned S_DATA_W    = 8;
    localparam int unsigned M_DATA_W    = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STORED_SECONDS = 2'd0,
        CFG_RECORD_START   = 2'd1,
        CFG_DEBUG_AT_START = 2'd2
    } cst_cfg_index_t;

    // chord codes: bit2 power, bit1 up, bit0 down
    localparam logic [2:0] KEY_NONE      = 3'b000;
    localparam logic [2:0] KEY_DOWN      = 3'b001;
    localparam logic [2:0] KEY_UP        = 3'b010;
    localparam logic [2:0] KEY_UP_DOWN   = 3'b011;
    localparam logic [2:0] KEY_POWER     = 3'b100;
    localparam logic [2:0] KEY_ALL       = 3'b111;

    localparam logic [11:0] DEFAULT_SECONDS = 12'd300;
    localparam logic [15:0] MIN_STORED      = 16'd5;
    localparam logic [15:0] LIMIT_SECONDS   = 16'd3600;
    localparam logic [7:0]  HEADER_BASE     = 8'h81;
    localparam logic [7:0]  HEADER_DEBUG    = 8'h02;
    localparam logic [9:0]  RECORD_STRIDE   = 10'd3;

    typedef struct packed {
        logic [11:0] preset;
        logic [11:0] remaining;
        logic [2:0]  chord;
        logic        dirty;
        logic        debug;
        logic        led;
        logic        shut;
        logic [8:0]  ptr;
    } cst_state_t;

    typedef struct packed {
        logic       second_tick;
        logic       power_key;
        logic       up_key;
        logic       down_key;
    } cst_keys_t;

    typedef struct packed {
        logic [7:0]  backup_header;
        logic [8:0]  backup_address;
        logic        backup_write;
        logic        debug_mode;
        logic [11:0] left_seconds;
        logic [11:0] preset_seconds;
        logic        led_on;
        logic        relay_on;
    } cst_result_t;

    function automatic logic [11:0] validated_seconds(input logic [15:0] s);
        logic [11:0] v;
        if (s < MIN_STORED || s > LIMIT_SECONDS) begin
            v = DEFAULT_SECONDS;
        end else begin
            v = s[11:0];
        end
        return v;
    endfunction

endpackage

FILE: src/countdown_shutdown_timer_core.sv
// ----------------------------------------------------------------------------
// countdown_shutdown_timer_core
// Self-shutdown relay timer: one poll request in, one status result out.
//
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    s_tdata  poll keys and tick
// m_       out  m_tvalid / m_tready    m_tdata  relay, led, times, backup
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle sustained while m_tready stays high; an accepted request
// passes the input register, then the state update into the result register
// aresetn is synchronous; state reloads from the register defaults
// s_tready drops only while both registers are full and m_tready is low
// configuration is always ready and reloads the derived state
// ----------------------------------------------------------------------------
module countdown_shutdown_timer_core
    import cst_pkg::*;
#(
    parameter int unsigned RECORD_AREA_END = 508,
    parameter int unsigned STEP_SECONDS    = 5,
    parameter int unsigned MAX_PRESET      = 3595
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // second_tick, power_key, up_key, down_key, zero pad
    input  logic [S_DATA_W-1:0]    s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // relay_on, led_on, preset_seconds, left_seconds, debug_mode,
    // backup_write, backup_address, backup_header, zero pad
    output logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_vld_reg;
    cst_keys_t   in_keys_reg;
    logic        out_vld_reg;
    cst_result_t out_res_reg;
    logic        out_free;
    logic        fire;
    cst_state_t  state_reg;
    cst_state_t  state_next;
    cst_result_t result;

    assign out_free  = ~out_vld_reg | m_tready;
    assign fire      = in_vld_reg & out_free;
    assign s_tready  = ~in_vld_reg | out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_keys_reg.second_tick <= s_tdata[0];
            in_keys_reg.power_key   <= s_tdata[1];
            in_keys_reg.up_key      <= s_tdata[2];
            in_keys_reg.down_key    <= s_tdata[3];
        end
    end

    cst_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .upd_en     (fire),
        .state_next (state_next),
        .state_reg  (state_reg)
    );

    cst_step #(
        .RECORD_AREA_END (RECORD_AREA_END),
        .STEP_SECONDS    (STEP_SECONDS),
        .MAX_PRESET      (MAX_PRESET)
    ) u_step (
        .keys       (in_keys_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_res_reg};

`ifndef SYNTHESIS
    a_write_only_at_shutdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.backup_write) |-> !out_res_reg.relay_on)
        else $error("backup record without shutdown");

    a_shutdown_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.shut |=> state_reg.shut)
        else $error("shutdown released");

    a_stall_only_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_result_follows_update: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("state updated without a result");
`endif

endmodule

FILE: src/cst_state.sv
// ----------------------------------------------------------------------------
// cst_state
// Timer state registers with configuration reload.
// ----------------------------------------------------------------------------
module cst_state
    import cst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   upd_en,
    input  cst_state_t             state_next,
    output cst_state_t             state_reg
);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.preset    <= DEFAULT_SECONDS;
            state_reg.remaining <= DEFAULT_SECONDS;
            state_reg.chord     <= KEY_NONE;
            state_reg.dirty     <= 1'b0;
            state_reg.debug     <= 1'b0;
            state_reg.led       <= 1'b0;
            state_reg.shut      <= 1'b0;
            state_reg.ptr       <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_STORED_SECONDS: begin
                    state_reg.preset    <= validated_seconds(cfg_data);
                    state_reg.remaining <= validated_seconds(cfg_data);
                end
                CFG_RECORD_START: begin
                    state_reg.ptr <= cfg_data[8:0];
                end
                CFG_DEBUG_AT_START: begin
                    state_reg.debug <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (upd_en) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/cst_step.sv
// ----------------------------------------------------------------------------
// cst_step
// One poll: tick, chord handling, zero check and backup record.
// ----------------------------------------------------------------------------
module cst_step
    import cst_pkg::*;
#(
    parameter int unsigned RECORD_AREA_END = 508,
    parameter int unsigned STEP_SECONDS    = 5,
    parameter int unsigned MAX_PRESET      = 3595
) (
    input  cst_keys_t   keys,
    input  cst_state_t  state_cur,
    output cst_state_t  state_next,
    output cst_result_t result
);

    localparam logic [12:0] STEP13     = 13'(STEP_SECONDS);
    localparam logic [12:0] TWO_STEP13 = 13'(2 * STEP_SECONDS);
    localparam logic [12:0] MAX13      = 13'(MAX_PRESET);
    localparam logic [12:0] SAT13      = 13'd4095;
    localparam logic [9:0]  AREA_END10 = 10'(RECORD_AREA_END);

    always_comb begin
        cst_state_t  st;
        logic [2:0]  pressed;
        logic [2:0]  code;
        logic [12:0] psum;
        logic [12:0] rsum;
        logic [9:0]  asum;
        logic        stop;
        logic        wr;
        logic [8:0]  addr;
        logic [7:0]  header;

        st      = state_cur;
        pressed = {keys.power_key, keys.up_key, keys.down_key};
        code    = KEY_NONE;
        stop    = 1'b0;
        wr      = 1'b0;
        addr    = '0;
        header  = '0;
        psum    = {1'b0, state_cur.preset} + STEP13;
        rsum    = '0;
        asum    = {1'b0, state_cur.ptr} + RECORD_STRIDE;

        if (!state_cur.shut) begin
            if (keys.second_tick) begin
                if (st.remaining != '0) begin
                    st.remaining = st.remaining - 12'd1;
                end
                st.led = ~st.led;
            end

            if (pressed != KEY_NONE) begin
                st.chord = st.chord | pressed;
            end else begin
                code     = st.chord;
                st.chord = KEY_NONE;
            end

            rsum = {1'b0, st.remaining} + STEP13;

            unique case (code)
                KEY_DOWN: begin
                    if ({1'b0, st.preset} >= TWO_STEP13) begin
                        st.preset = 12'({1'b0, st.preset} - STEP13);
                    end
                    if ({1'b0, st.remaining} > STEP13) begin
                        st.remaining = 12'({1'b0, st.remaining} - STEP13);
                    end else begin
                        st.remaining = '0;
                    end
                    st.dirty = 1'b1;
                end
                KEY_UP: begin
                    if (psum > MAX13) begin
                        st.preset = MAX13[11:0];
                    end else begin
                        st.preset    = (psum > SAT13) ? SAT13[11:0] : psum[11:0];
                        st.remaining = (rsum > SAT13) ? SAT13[11:0] : rsum[11:0];
                    end
                    st.dirty = 1'b1;
                end
                KEY_UP_DOWN: begin
                    st.preset    = DEFAULT_SECONDS;
                    st.remaining = DEFAULT_SECONDS;
                    st.dirty     = 1'b1;
                end
                KEY_POWER: begin
                    stop = 1'b1;
                end
                KEY_ALL: begin
                    st.debug = ~st.debug;
                    st.dirty = 1'b1;
                end
                default: begin
                end
            endcase

            if (st.remaining == '0) begin
                stop = 1'b1;
            end

            if (stop) begin
                st.shut = 1'b1;
                if (st.dirty) begin
                    addr   = (asum >= AREA_END10) ? 9'd0 : asum[8:0];
                    st.ptr = addr;
                    header = HEADER_BASE | (st.debug ? HEADER_DEBUG : 8'h00);
                    wr     = 1'b1;
                end
            end
        end

        state_next             = st;
        result.relay_on        = ~st.shut;
        result.led_on          = st.shut | st.led;
        result.preset_seconds  = st.preset;
        result.left_seconds    = st.remaining;
        result.debug_mode      = st.debug;
        result.backup_write    = wr;
        result.backup_address  = addr;
        result.backup_header   = header;
    end

endmodule

FILE: test/cst_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cst_checker
// Watches the poll, status and configuration channels of the shutdown timer,
// keeps its own model of the timer state and compares every status result
// field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
module cst_checker
    import cst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int STEP_SECONDS    = 5;
    localparam int MAX_PRESET      = 3595;
    localparam int RECORD_AREA_END = 508;
    localparam int SECONDS_CEILING = 4095;

    int          preset_s;
    int          left_s;
    logic [2:0]  held_keys;
    logic        dirty;
    logic        debug_on;
    logic        led;
    logic        shut;
    logic [8:0]  record_ptr;
    int          fault_count = 0;
    cst_result_t status_due[$];
    cst_result_t want;
    cst_result_t got;

    function automatic int reload_seconds(input logic [15:0] stored);
        int secs;
        if (stored < MIN_STORED || stored > LIMIT_SECONDS) begin
            secs = int'(DEFAULT_SECONDS);
        end else begin
            secs = int'(stored);
        end
        return secs;
    endfunction

    // one poll: tick, then chord release, then the zero check
    function automatic cst_result_t poll_timer(input logic tick, input logic [2:0] keys);
        cst_result_t st;
        logic [2:0]  code;
        logic        stop;
        int          addr;
        st   = '0;
        code = KEY_NONE;
        stop = 1'b0;
        if (!shut) begin
            if (tick) begin
                if (left_s > 0) left_s--;
                led = ~led;
            end
            if (keys != KEY_NONE) begin
                held_keys = held_keys | keys;
            end else begin
                code      = held_keys;
                held_keys = KEY_NONE;
            end
            case (code)
                KEY_DOWN: begin
                    if (preset_s >= 2 * STEP_SECONDS) preset_s -= STEP_SECONDS;
                    left_s = (left_s > STEP_SECONDS) ? left_s - STEP_SECONDS : 0;
                    dirty  = 1'b1;
                end
                KEY_UP: begin
                    if (preset_s + STEP_SECONDS > MAX_PRESET) begin
                        preset_s = MAX_PRESET;
                    end else begin
                        preset_s += STEP_SECONDS;
                        left_s = (left_s + STEP_SECONDS > SECONDS_CEILING) ?
                                 SECONDS_CEILING : left_s + STEP_SECONDS;
                    end
                    dirty = 1'b1;
                end
                KEY_UP_DOWN: begin
                    preset_s = int'(DEFAULT_SECONDS);
                    left_s   = int'(DEFAULT_SECONDS);
                    dirty    = 1'b1;
                end
                KEY_POWER: begin
                    stop = 1'b1;
                end
                KEY_ALL: begin
                    debug_on = ~debug_on;
                    dirty    = 1'b1;
                end
                default: ;
            endcase
            if (left_s == 0) stop = 1'b1;
            if (stop) begin
                shut = 1'b1;
                if (dirty) begin
                    addr = int'(record_ptr) + int'(RECORD_STRIDE);
                    if (addr >= RECORD_AREA_END) addr = 0;
                    record_ptr        = addr[8:0];
                    st.backup_write   = 1'b1;
                    st.backup_address = addr[8:0];
                    st.backup_header  = HEADER_BASE | (debug_on ? HEADER_DEBUG : 8'h00);
                end
            end
        end
        st.relay_on       = ~shut;
        st.led_on         = shut | led;
        st.preset_seconds = preset_s[11:0];
        st.left_seconds   = left_s[11:0];
        st.debug_mode     = debug_on;
        return st;
    endfunction

    task automatic report_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            if (fault_count < 10) begin
                $display("%t %s: expected %0d, got %0d", $time, what, exp_val, act_val);
            end
            fault_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            preset_s   = int'(DEFAULT_SECONDS);
            left_s     = int'(DEFAULT_SECONDS);
            held_keys  = KEY_NONE;
            dirty      = 1'b0;
            debug_on   = 1'b0;
            led        = 1'b0;
            shut       = 1'b0;
            record_ptr = 9'd0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STORED_SECONDS: begin
                        preset_s = reload_seconds(cfg_data);
                        left_s   = preset_s;
                    end
                    CFG_RECORD_START: begin
                        record_ptr = cfg_data[8:0];
                    end
                    CFG_DEBUG_AT_START: begin
                        debug_on = cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(cst_result_t)-1:0];
                if (status_due.size() == 0) begin
                    if (fault_count < 10) $display("%t status with no poll pending", $time);
                    fault_count++;
                end else begin
                    want = status_due.pop_front();
                    report_field("relay_on", want.relay_on, got.relay_on);
                    report_field("led_on", want.led_on, got.led_on);
                    report_field("preset_seconds", want.preset_seconds, got.preset_seconds);
                    report_field("left_seconds", want.left_seconds, got.left_seconds);
                    report_field("debug_mode", want.debug_mode, got.debug_mode);
                    report_field("backup_write", want.backup_write, got.backup_write);
                    report_field("backup_address", want.backup_address, got.backup_address);
                    report_field("backup_header", want.backup_header, got.backup_header);
                end
            end
            // tdata: bit0 tick, bit1 power, bit2 up, bit3 down
            if (s_tvalid && s_tready) begin
                status_due.push_back(poll_timer(s_tdata[0], {s_tdata[1], s_tdata[2], s_tdata[3]}));
            end
        end
        pending    <= status_due.size();
        mismatches <= fault_count;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives poll requests and register writes into the shutdown timer core with
// random gaps and stalls, then waits for the checker and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import cst_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int         mismatches;
    int         pending;
    int         stall_left  = 0;
    int         stall_draw  = 0;
    int         polls_sent  = 0;
    logic       rx_burst    = 1'b0;
    logic       tx_burst    = 1'b0;
    logic       guard_power = 1'b1;
    logic [2:0] keys_held   = KEY_NONE;

    countdown_shutdown_timer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cst_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // status side: random stall after each accepted status
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            stall_draw = rx_burst ? 0 : $urandom_range(0, 19);
            m_tready   <= (stall_draw == 0);
            stall_left <= stall_draw;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
    end

    function automatic logic [15:0] phase_seconds();
        logic [15:0] secs;
        case ($urandom_range(0, 7))
            0:       secs = 16'd0;
            1:       secs = 16'd4;
            2:       secs = 16'd3601;
            3:       secs = 16'hFFFF;
            4:       secs = 16'd300;
            5:       secs = 16'd3600;
            6:       secs = 16'($urandom_range(300, 3600));
            default: secs = 16'($urandom_range(3601, 65535));
        endcase
        return secs;
    endfunction

    function automatic logic [8:0] record_draw();
        logic [8:0] addr;
        case ($urandom_range(0, 4))
            0:       addr = 9'd0;
            1:       addr = 9'd511;
            2:       addr = 9'd505;
            3:       addr = 9'd504;
            default: addr = 9'($urandom_range(0, 511));
        endcase
        return addr;
    endfunction

    // a power-alone release would shut the timer down for good, so while
    // guarded it is turned into an up press
    task automatic send_poll(input logic tick, input logic [2:0] keys);
        int         gap;
        logic [2:0] k;
        k = keys;
        if (guard_power && k == KEY_NONE && keys_held == KEY_POWER) k = KEY_UP;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, k[0], k[1], k[2], tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        keys_held = (k == KEY_NONE) ? KEY_NONE : (keys_held | k);
        polls_sent++;
    endtask

    task automatic press_chord(input logic [2:0] chord_code);
        int         n;
        logic [2:0] k;
        n = $urandom_range(1, 4);
        repeat (n - 1) begin
            k = chord_code & 3'($urandom_range(1, 7));
            if (k == KEY_NONE) k = chord_code;
            send_poll(1'($urandom_range(0, 1)), k);
        end
        send_poll(1'($urandom_range(0, 1)), chord_code);
        send_poll(1'($urandom_range(0, 1)), KEY_NONE);
    endtask

    task automatic release_keys();
        while (keys_held != KEY_NONE) send_poll(1'($urandom_range(0, 1)), KEY_NONE);
    endtask

    task automatic run_phase(input int n);
        int start;
        start = polls_sent;
        while (polls_sent - start < n) begin
            case ($urandom_range(0, 9))
                0, 1:    press_chord(KEY_DOWN);
                2, 3:    press_chord(KEY_UP);
                4:       press_chord(KEY_UP_DOWN);
                5:       press_chord(KEY_ALL);
                6:       press_chord($urandom_range(0, 1) ? (KEY_POWER | KEY_UP) :
                                                            (KEY_POWER | KEY_DOWN));
                7:       repeat ($urandom_range(1, 3)) send_poll(1'($urandom_range(0, 1)),
                                                                 KEY_NONE);
                default: send_poll(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            endcase
        end
        release_keys();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cst_cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // mask bit0 seconds, bit1 record start, bit2 debug
    task automatic load_settings(input logic [15:0] secs, input logic [8:0] rec,
                                 input logic dbg, input logic [2:0] mask);
        if (mask[0]) write_reg(CFG_STORED_SECONDS, secs);
        if (mask[1]) write_reg(CFG_RECORD_START, {7'd0, rec});
        if (mask[2]) write_reg(CFG_DEBUG_AT_START, {15'd0, dbg});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STORED_SECONDS;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: chord presses and releases from the reset defaults
        send_poll(1'b0, KEY_NONE);
        send_poll(1'b1, KEY_NONE);
        send_poll(1'b0, KEY_DOWN);
        send_poll(1'b1, KEY_NONE);
        send_poll(1'b0, KEY_UP);
        send_poll(1'b1, KEY_UP_DOWN);
        send_poll(1'b0, KEY_NONE);
        send_poll(1'b1, KEY_ALL);
        send_poll(1'b0, KEY_NONE);
        send_poll(1'b0, KEY_POWER);
        send_poll(1'b0, KEY_UP);
        send_poll(1'b0, KEY_NONE);
        send_poll(1'b1, KEY_DOWN);
        send_poll(1'b0, KEY_POWER);
        send_poll(1'b1, KEY_NONE);
        settle();
        // preset capped while the time left stays
        load_settings(16'd3600, 9'd511, 1'b1, 3'b111);
        send_poll(1'b0, KEY_UP);
        send_poll(1'b0, KEY_NONE);
        settle();
        load_settings(16'd3590, 9'd0, 1'b0, 3'b001);
        send_poll(1'b0, KEY_UP);
        send_poll(1'b0, KEY_NONE);
        settle();
        // tick runs the time out in the same poll that releases up
        load_settings(16'd5, 9'd0, 1'b0, 3'b001);
        repeat (4) send_poll(1'b1, KEY_NONE);
        send_poll(1'b0, KEY_UP);
        send_poll(1'b1, KEY_NONE);

        while (polls_sent < 1600) begin
            settle();
            load_settings(phase_seconds(), record_draw(), 1'($urandom_range(0, 1)),
                          {2'($urandom_range(0, 3)), 1'b1});
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst <= ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(10, 70));
        end

        // shutdown, once per run
        settle();
        tx_burst = 1'b0;
        rx_burst <= 1'b0;
        guard_power = 1'b0;
        case ($urandom_range(0, 2))
            0: begin
                load_settings(phase_seconds(), record_draw(), 1'($urandom_range(0, 1)), 3'b111);
                send_poll(1'b0, KEY_POWER);
                send_poll(1'b1, KEY_NONE);
            end
            1: begin
                // down at the preset floor empties the time left
                load_settings(16'd5, record_draw(), 1'($urandom_range(0, 1)), 3'b111);
                send_poll(1'b0, KEY_DOWN);
                send_poll(1'b0, KEY_NONE);
            end
            default: begin
                load_settings(16'($urandom_range(5, 9)), record_draw(),
                              1'($urandom_range(0, 1)), 3'b111);
                repeat (12) send_poll(1'b1, KEY_NONE);
            end
        endcase
        repeat (30) send_poll(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        settle();
        load_settings(16'($urandom_range(0, 65535)), record_draw(),
                      1'($urandom_range(0, 1)), 3'b111);
        repeat (10) send_poll(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/cst_pkg.sv
src/cst_state.sv
src/cst_step.sv
src/countdown_shutdown_timer_core.sv
test/cst_checker.sv
test/tb.sv
